FILE: hdl/glw_pkg.sv
// Shared types and constants of the grid line walk block.
package glw_pkg;

   localparam int COORD_W = 8;
   localparam int CLASS_W = 6;
   localparam int COUNT_W = COORD_W + 1;
   localparam int NUM_W = COORD_W + 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Pass band of the class check, one bit wider than a class
   localparam logic [CLASS_W:0] CLASS_LO = 7'h11;
   localparam logic [CLASS_W:0] CLASS_HI = 7'h40;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_WALK = 1'b1;

   localparam logic [1:0] OUTCOME_WRITE = 2'd0;
   localparam logic [1:0] OUTCOME_HIT = 2'd1;
   localparam logic [1:0] OUTCOME_CLEAR = 2'd2;
   localparam logic [1:0] OUTCOME_LEFT = 2'd3;

   localparam logic [1:0] CSR_LO_X = 2'd0;
   localparam logic [1:0] CSR_LO_Y = 2'd1;
   localparam logic [1:0] CSR_HI_X = 2'd2;
   localparam logic [1:0] CSR_HI_Y = 2'd3;

   typedef logic signed [NUM_W-1:0] num_type;

   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [CLASS_W-1:0] class_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [COORD_W-1:0] hit_x;
      logic [COORD_W-1:0] hit_y;
      logic [CLASS_W-1:0] hit_class;
   } rsp_item_type;

   // Prepared command handed from the front part to the walker
   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CLASS_W-1:0] class_value;
      logic               major_x;
      logic               neg_x;
      logic               neg_y;
      logic [COUNT_W-1:0] count;
      num_type            num;
      num_type            add_minor;
      num_type            add_both;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] lo_x;
      logic [COORD_W-1:0] lo_y;
      logic [COORD_W-1:0] hi_x;
      logic [COORD_W-1:0] hi_y;
   } extent_type;

   typedef enum logic {
      BK_IDLE,
      BK_WALK
   } back_state_type;

endpackage

FILE: hdl/glw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glw_ram
   #(parameter int WIDTH = 6,
     parameter int DEPTH = 65536)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/glw_queue.sv
// Small first-in first-out queue built from registers.
module glw_queue
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 2)
   (input  logic             clock,
    input  logic             reset,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/glw_front.sv
// Front part: accepts request transactions and prepares the line walk setup.
module glw_front
   import glw_pkg::*;
   (input  logic         clock,
    input  logic         reset,
    input  logic         push,
    output logic         full,
    input  req_item_type req_item,
    input  logic         cmd_full,
    output logic         cmd_push,
    output cmd_type      cmd_item);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic [COORD_W-1:0] dx, dy, dmaj, dmin;
   logic         neg_x, neg_y, major_x;

   assign full = valid_ff && cmd_full;
   assign cmd_push = valid_ff && !cmd_full;

   always_comb begin
      valid_in = valid_ff;
      if (push && !full) begin
         valid_in = 1'b1;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         item_ff <= req_item;
      end
   end

   // Deltas, directions and the error term of the Bresenham walk
   always_comb begin
      neg_x = item_ff.dest_x < item_ff.cell_x;
      neg_y = item_ff.dest_y < item_ff.cell_y;
      dx = neg_x ? item_ff.cell_x - item_ff.dest_x : item_ff.dest_x - item_ff.cell_x;
      dy = neg_y ? item_ff.cell_y - item_ff.dest_y : item_ff.dest_y - item_ff.cell_y;
      major_x = dx >= dy;
      dmaj = major_x ? dx : dy;
      dmin = major_x ? dy : dx;

      cmd_item.op = item_ff.req_type;
      cmd_item.x = item_ff.cell_x;
      cmd_item.y = item_ff.cell_y;
      cmd_item.class_value = item_ff.class_value;
      cmd_item.major_x = major_x;
      cmd_item.neg_x = neg_x;
      cmd_item.neg_y = neg_y;
      cmd_item.count = {1'b0, dmaj} + 1'b1;
      cmd_item.num = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      cmd_item.add_minor = $signed({2'b00, dmin, 1'b0});
      cmd_item.add_both = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
   end

endmodule

FILE: hdl/glw_back.sv
// Back part: performs map writes and walks lines through the class map.
module glw_back
   import glw_pkg::*;
   #(parameter int COORD_BITS = 8)
   (input  logic         clock,
    input  logic         reset,
    input  extent_type   extent,
    input  logic         cmd_empty,
    output logic         cmd_pop,
    input  cmd_type      cmd_item,
    input  logic         rsp_full,
    output logic         rsp_push,
    output rsp_item_type rsp_data);

   localparam int ADDR_BITS = 2 * COORD_BITS;
   localparam int MAP_DEPTH = 1 << ADDR_BITS;

   back_state_type     state_ff, state_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   num_type            num_ff, num_in;
   num_type            add_minor_ff, add_minor_in, add_both_ff, add_both_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               major_x_ff, major_x_in, neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic               p_valid_ff, p_valid_in, p_last_ff, p_last_in;
   logic [COORD_W-1:0] p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic               oob_ff, oob_in;

   logic                 wr_en, rd_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [CLASS_W-1:0]   rd_data;
   logic                 in_extent, is_hit;
   logic [COORD_W-1:0]   step_x, step_y;

   function automatic logic [ADDR_BITS-1:0] map_addr(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y);
      return {COORD_BITS'(x), COORD_BITS'(y)};
   endfunction

   glw_ram #(.WIDTH(CLASS_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_item.class_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data));

   assign in_extent = (cur_x_ff >= extent.lo_x) && (cur_x_ff <= extent.hi_x) &&
                      (cur_y_ff >= extent.lo_y) && (cur_y_ff <= extent.hi_y);
   assign is_hit = ({1'b0, rd_data} < CLASS_LO) || ({1'b0, rd_data} > CLASS_HI);
   assign step_x = neg_x_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
   assign step_y = neg_y_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
   assign wr_addr = map_addr(cmd_item.x, cmd_item.y);
   assign rd_addr = map_addr(cur_x_ff, cur_y_ff);

   always_comb begin
      state_in = state_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      num_in = num_ff;
      add_minor_in = add_minor_ff;
      add_both_in = add_both_ff;
      remain_in = remain_ff;
      major_x_in = major_x_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      p_valid_in = 1'b0;
      p_last_in = p_last_ff;
      p_x_in = p_x_ff;
      p_y_in = p_y_ff;
      oob_in = oob_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      wr_en = 1'b0;
      rd_en = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            // Start only with room for the result, so the finish never waits
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               if (cmd_item.op == REQ_WRITE) begin
                  wr_en = 1'b1;
                  rsp_push = 1'b1;
                  rsp_data.outcome = OUTCOME_WRITE;
               end else begin
                  cur_x_in = cmd_item.x;
                  cur_y_in = cmd_item.y;
                  num_in = cmd_item.num;
                  add_minor_in = cmd_item.add_minor;
                  add_both_in = cmd_item.add_both;
                  remain_in = cmd_item.count;
                  major_x_in = cmd_item.major_x;
                  neg_x_in = cmd_item.neg_x;
                  neg_y_in = cmd_item.neg_y;
                  oob_in = 1'b0;
                  state_in = BK_WALK;
               end
            end
         end
         BK_WALK: begin
            // Issue the read of the current cell and advance
            if (!oob_ff && remain_ff != '0) begin
               if (in_extent) begin
                  rd_en = 1'b1;
                  p_valid_in = 1'b1;
                  p_x_in = cur_x_ff;
                  p_y_in = cur_y_ff;
                  p_last_in = (remain_ff == COUNT_W'(1));
                  remain_in = remain_ff - 1'b1;
                  if (num_ff[NUM_W-1]) begin
                     num_in = num_ff + add_minor_ff;
                     if (major_x_ff) begin
                        cur_x_in = step_x;
                     end else begin
                        cur_y_in = step_y;
                     end
                  end else begin
                     num_in = num_ff + add_both_ff;
                     cur_x_in = step_x;
                     cur_y_in = step_y;
                  end
               end else begin
                  oob_in = 1'b1;
               end
            end
            // Check the cell read in the previous cycle
            if (p_valid_ff) begin
               if (is_hit) begin
                  rsp_push = 1'b1;
                  rsp_data.outcome = OUTCOME_HIT;
                  rsp_data.hit_x = p_x_ff;
                  rsp_data.hit_y = p_y_ff;
                  rsp_data.hit_class = rd_data;
                  state_in = BK_IDLE;
               end else if (p_last_ff) begin
                  rsp_push = 1'b1;
                  rsp_data.outcome = OUTCOME_CLEAR;
                  state_in = BK_IDLE;
               end
            end else if (oob_ff) begin
               rsp_push = 1'b1;
               rsp_data.outcome = OUTCOME_LEFT;
               state_in = BK_IDLE;
            end
            if (state_in == BK_IDLE) begin
               p_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         p_valid_ff <= 1'b0;
         oob_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_valid_ff <= p_valid_in;
         oob_ff <= oob_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      num_ff <= num_in;
      add_minor_ff <= add_minor_in;
      add_both_ff <= add_both_in;
      remain_ff <= remain_in;
      major_x_ff <= major_x_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      p_last_ff <= p_last_in;
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
   end

endmodule

FILE: hdl/grid_line_walk_first_hit.sv
// Top level of the grid line walk block: register port, queues and walker.
//
// Request channel: a transaction is taken when push is high and full is low.
// A write transaction stores one cell class in the map; a walk transaction
// steps from the start cell to the end cell, both included, and stops at the
// first cell whose class lies outside 0x11..0x40 or that leaves the extent.
// Result channel: the oldest result sits on rsp_item while empty is low and
// is taken when pop is high. Every request gives exactly one result.
// The walker makes one map read per cycle through a single registered read port
// while a walk runs, and takes no new command until the walk has its result.
// A stalled receiver fills the two-entry result queue; the walker then holds
// its next command, the two-entry command queue and the front register fill,
// and full rises. The extent registers sit at byte addresses 0, 4, 8 and 12;
// the user must see that they are written only while the block is idle, as
// the block itself does not enforce it. Reset empties both queues, returns
// the walker to idle and sets the extent to the full 0..255 range.
// The map holds no reset value: every cell must be written before a walk
// reads it.
module grid_line_walk_first_hit
   import glw_pkg::*;
   #(parameter int COORD_BITS = 8)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  push,
    output logic                  full,
    input  req_item_type          req_item,
    output logic                  empty,
    input  logic                  pop,
    output rsp_item_type          rsp_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CSR_ADDR_W-1:0] paddr,
    input  logic [CSR_DATA_W-1:0] pwdata,
    output logic [CSR_DATA_W-1:0] prdata,
    output logic                  pready);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_item_type);

   extent_type         extent_ff;
   logic [1:0]         csr_index;
   logic [COORD_W-1:0] csr_value;

   logic         cmd_full, cmd_push, cmd_empty, cmd_pop;
   cmd_type      front_cmd;
   logic [CMD_W-1:0] cmd_rd_data;
   logic         rsp_full, rsp_push;
   rsp_item_type back_rsp;
   logic [RSP_W-1:0] rsp_rd_data;

   assign pready = 1'b1;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_ff.lo_x <= '0;
         extent_ff.lo_y <= '0;
         extent_ff.hi_x <= '1;
         extent_ff.hi_y <= '1;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            CSR_LO_X: extent_ff.lo_x <= pwdata[COORD_W-1:0];
            CSR_LO_Y: extent_ff.lo_y <= pwdata[COORD_W-1:0];
            CSR_HI_X: extent_ff.hi_x <= pwdata[COORD_W-1:0];
            CSR_HI_Y: extent_ff.hi_y <= pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_LO_X: csr_value = extent_ff.lo_x;
         CSR_LO_Y: csr_value = extent_ff.lo_y;
         CSR_HI_X: csr_value = extent_ff.hi_x;
         CSR_HI_Y: csr_value = extent_ff.hi_y;
         default:  csr_value = '0;
      endcase
      prdata = CSR_DATA_W'(csr_value);
   end

   glw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_item (front_cmd));

   glw_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty));

   glw_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .extent    (extent_ff),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_type'(cmd_rd_data)),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp));

   glw_queue #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_rd_data),
      .empty   (empty));

   assign rsp_item = rsp_item_type'(rsp_rd_data);

endmodule

FILE: hdl/glw_check.sv
// Port-level assertions for the grid line walk block and their bind.
module glw_check
   import glw_pkg::*;
   (input logic         clock,
    input logic         reset,
    input logic         full,
    input logic         empty,
    input logic         pop,
    input rsp_item_type rsp_item);

   // Queues come out of reset empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("block not idle after reset");

   // Only a hit carries coordinates and a class
   a_non_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.outcome != OUTCOME_HIT) |->
         (rsp_item.hit_x == '0 && rsp_item.hit_y == '0 && rsp_item.hit_class == '0))
      else $error("non-hit result with nonzero hit fields");

   // A reported blocking class must fail the pass band
   a_hit_class: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.outcome == OUTCOME_HIT) |->
         ({1'b0, rsp_item.hit_class} < CLASS_LO || {1'b0, rsp_item.hit_class} > CLASS_HI))
      else $error("hit reported on a passable class");

   // A result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed or dropped");

endmodule

bind grid_line_walk_first_hit glw_check u_glw_check (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item));
